// ===== rtl/snnp_pkg.sv =====
// Shared types and constants for the sequential nearest-neighbor pick block.
package snnp_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_DIMS   = 8;

    localparam int NUM_COORDS = 8;
    localparam int COORD_W    = 16;
    localparam int ABS_W      = 16;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int PAIR_W     = SQ_W + 1;
    localparam int QUAD_W     = SQ_W + 2;
    localparam int DIST_W     = SQ_W + 3;
    localparam int IDX_W      = 11;
    localparam int DIMS_W     = 4;
    localparam int CMD_W      = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_DIMS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
        logic signed [COORD_W-1:0] coord_3;
        logic signed [COORD_W-1:0] coord_4;
        logic signed [COORD_W-1:0] coord_5;
        logic signed [COORD_W-1:0] coord_6;
        logic signed [COORD_W-1:0] coord_7;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] picked_index;
        logic             none_left;
    } t_out_item;

endpackage

// ===== rtl/sequential_nearest_neighbor_pick.sv =====
// Nearest remaining point search over a stored point set, with removal on pick.
// A load, clear or unknown command completes in the cycle it is accepted.
// A query scans the point memory (one stored point per cycle) through the 7-stage distance
// pipeline behind it and then gives its result transaction; one query is in flight at a
// time, and a stalled output holds the result back. Reset: point count clears, r_dims
// returns to 8.
module sequential_nearest_neighbor_pick #(
    parameter int MAX_POINTS = snnp_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = snnp_pkg::DEF_MAX_DIMS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Command channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  snnp_pkg::t_in_item                   i_in_data,
    // Result channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output snnp_pkg::t_out_item                  o_out_data,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [snnp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [snnp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [snnp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import snnp_pkg::*;

    // Address width indexes the memories; count width holds MAX_POINTS itself.
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int ROW_W = MAX_DIMS * COORD_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [DIMS_W-1:0] r_dims;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_DIMS)) begin
            r_dims <= pwdata[DIMS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_DIMS) begin
            prdata[DIMS_W-1:0] = r_dims;
        end
    end

    // ------------------------------------------------------------------
    // Input transaction decode. Commands are only taken while idle, so the
    // scan never sees the point set change under it.
    // ------------------------------------------------------------------
    logic                      w_in_acc;
    t_cmd                      w_cmd;
    logic signed [COORD_W-1:0] w_in_coord [NUM_COORDS];
    logic [ROW_W-1:0]          w_wr_row;
    logic [DIMS_W-1:0]         w_eff_dims;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cmd      = t_cmd'(i_in_data.cmd);

    always_comb begin
        w_in_coord[0] = i_in_data.coord_0;
        w_in_coord[1] = i_in_data.coord_1;
        w_in_coord[2] = i_in_data.coord_2;
        w_in_coord[3] = i_in_data.coord_3;
        w_in_coord[4] = i_in_data.coord_4;
        w_in_coord[5] = i_in_data.coord_5;
        w_in_coord[6] = i_in_data.coord_6;
        w_in_coord[7] = i_in_data.coord_7;
    end

    always_comb begin
        w_wr_row = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_wr_row[d*COORD_W +: COORD_W] = w_in_coord[d];
        end
    end

    // A zero setting counts as one dimension; anything above MAX_DIMS is clipped.
    always_comb begin
        if (r_dims == '0) begin
            w_eff_dims = DIMS_W'(1);
        end else if (r_dims > DIMS_W'(MAX_DIMS)) begin
            w_eff_dims = DIMS_W'(MAX_DIMS);
        end else begin
            w_eff_dims = r_dims;
        end
    end

    // ------------------------------------------------------------------
    // Point count and query capture.
    // ------------------------------------------------------------------
    logic [CW-1:0]             r_count;
    logic                      w_load;
    logic signed [COORD_W-1:0] r_q [NUM_COORDS];
    logic [DIMS_W-1:0]         r_nd;

    assign w_load = w_in_acc && (w_cmd == CMD_LOAD) && (r_count < CW'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_load) begin
            r_count <= r_count + CW'(1);
        end else if (w_in_acc && (w_cmd == CMD_CLEAR)) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_cmd == CMD_QUERY)) begin
            r_q  <= w_in_coord;
            r_nd <= w_eff_dims;
        end
    end

    // ------------------------------------------------------------------
    // Memories. The point memory holds one row of all coordinates per point.
    // The removed memory has no reset: every point below the count was
    // written with a cleared removed bit by its load, and a clear only drops
    // the count, so stale bits are never read.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] r_point_mem   [MAX_POINTS];
    logic             r_removed_mem [MAX_POINTS];

    logic [CW-1:0]    r_scan_addr;
    logic             w_issue;
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_removed;

    logic             w_rm_we;
    logic [AW-1:0]    w_rm_addr;
    logic             w_rm_data;

    logic             r_found;
    logic [AW-1:0]    r_best_idx;
    logic             w_deliver;

    assign w_issue = (r_state == ST_SCAN) && (r_scan_addr < r_count);

    // Removed bits are written either by a load (cleared) or by the end of a
    // query (set). The two never fall in the same cycle.
    always_comb begin
        w_rm_we   = 1'b0;
        w_rm_addr = r_count[AW-1:0];
        w_rm_data = 1'b0;
        if (w_load) begin
            w_rm_we = 1'b1;
        end else if (w_deliver && r_found) begin
            w_rm_we   = 1'b1;
            w_rm_addr = r_best_idx;
            w_rm_data = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_point_mem[r_count[AW-1:0]] <= w_wr_row;
        end
        if (w_rm_we) begin
            r_removed_mem[w_rm_addr] <= w_rm_data;
        end
        r_rd_row     <= r_point_mem[r_scan_addr[AW-1:0]];
        r_rd_removed <= r_removed_mem[r_scan_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
        end else if (w_in_acc && (w_cmd == CMD_QUERY)) begin
            r_scan_addr <= '0;
        end else if (w_issue) begin
            r_scan_addr <= r_scan_addr + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Distance pipeline: read, |difference|, square, pair sum, quad sum,
    // total, compare. Each stage carries a valid bit and the point index.
    // Removed points are dropped as soon as their read data is back.
    // ------------------------------------------------------------------
    logic              r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [AW-1:0]     r_i1, r_i2, r_i3, r_i4, r_i5, r_i6;
    logic [ABS_W-1:0]  r_abs  [NUM_COORDS];
    logic [SQ_W-1:0]   r_sq   [NUM_COORDS];
    logic [PAIR_W-1:0] r_pair [NUM_COORDS/2];
    logic [QUAD_W-1:0] r_quad [NUM_COORDS/4];
    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_best_dist;
    logic              w_pipe_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1 && !r_rd_removed;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_scan_addr[AW-1:0];
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_i5 <= r_i4;
        r_i6 <= r_i5;
    end

    for (genvar d = 0; d < NUM_COORDS; d++) begin : g_lane
        logic signed [COORD_W-1:0] w_p;
        logic signed [COORD_W:0]   w_diff;
        logic [COORD_W:0]          w_mag;

        if (d < MAX_DIMS) begin : g_used
            assign w_p = r_rd_row[d*COORD_W +: COORD_W];
        end else begin : g_unused
            assign w_p = '0;
        end

        // The magnitude of a 17-bit difference of two 16-bit values fits 16 bits.
        assign w_diff = {w_p[COORD_W-1], w_p} - {r_q[d][COORD_W-1], r_q[d]};
        assign w_mag  = w_diff[COORD_W] ? (~w_diff + 1'b1) : w_diff;

        always_ff @(posedge i_clk) begin
            if (DIMS_W'(d) < r_nd) begin
                r_abs[d] <= w_mag[ABS_W-1:0];
            end else begin
                r_abs[d] <= '0;
            end
            r_sq[d] <= r_abs[d] * r_abs[d];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_COORDS / 2; k++) begin
            r_pair[k] <= PAIR_W'(r_sq[2*k]) + PAIR_W'(r_sq[2*k+1]);
        end
        for (int k = 0; k < NUM_COORDS / 4; k++) begin
            r_quad[k] <= QUAD_W'(r_pair[2*k]) + QUAD_W'(r_pair[2*k+1]);
        end
        r_sum <= DIST_W'(r_quad[0]) + DIST_W'(r_quad[1]);
    end

    // Only a strictly smaller distance replaces the best, so ties keep the
    // lowest index since points arrive in index order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_in_acc && (w_cmd == CMD_QUERY)) begin
            r_found <= 1'b0;
        end else if (r_v6 && (!r_found || (r_sum < r_best_dist))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v6 && (!r_found || (r_sum < r_best_dist))) begin
            r_best_dist <= r_sum;
            r_best_idx  <= r_i6;
        end
    end

    assign w_pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5 || r_v6;

    // ------------------------------------------------------------------
    // Sequencer and output register. The result waits in DONE only while an
    // earlier result is still held by a stalled receiver.
    // ------------------------------------------------------------------
    logic             r_out_valid;
    t_out_item        r_out;
    logic [AW:0]      w_idx_one;

    assign w_deliver = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign w_idx_one = {1'b0, r_best_idx} + (AW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (w_cmd == CMD_QUERY)) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!w_issue && !w_pipe_busy) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_deliver) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_deliver) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_deliver) begin
            if (r_found) begin
                r_out.picked_index <= IDX_W'(w_idx_one);
                r_out.none_left    <= 1'b0;
            end else begin
                r_out.picked_index <= '0;
                r_out.none_left    <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_read_past_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_scan_addr < r_count))
        else $error("scan read beyond the stored point count");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deliver && r_found) |-> (CW'(r_best_idx) < r_count))
        else $error("picked point lies beyond the stored point count");

    a_none_left_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.none_left) |-> (o_out_data.picked_index == '0))
        else $error("none_left result carries a nonzero index");

    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !w_pipe_busy)
        else $error("result formed while the distance pipeline is still busy");

endmodule
